>>> rtl/dds_wcs_pkg.sv
// Constants for the DDS waveform command sequencer.
package dds_wcs_pkg;

    // Generator clock divided by 2^6: tuning = floor(f * 2^22 / DIV_D)
    localparam int unsigned DivWidth = 19;
    localparam logic [DivWidth-1:0] DIV_D = 19'd390625;
    // floor(2^50 / DIV_D)
    localparam logic [31:0] DIV_RECIP = 32'd2882303761;

    // Phase: floor(p * 512 / 45), reciprocal floor(2^24 / 45)
    localparam logic [5:0]  PH_DIV   = 6'd45;
    localparam logic [18:0] PH_RECIP = 19'd372827;
    localparam logic [8:0]  DEG_MAX  = 9'd359;

    // Command words
    localparam logic [15:0] CMD_RESET_ON  = 16'h0100;
    localparam logic [15:0] CMD_B28_RESET = 16'h2100;
    localparam logic [15:0] CMD_FREQ0     = 16'h4000;
    localparam logic [15:0] CMD_PHASE0    = 16'hC000;
    localparam logic [15:0] CTRL_BASE     = 16'h2000;
    localparam logic [15:0] CTRL_TRIANGLE = 16'h0002;
    localparam logic [15:0] CTRL_SQUARE   = 16'h0028;

    // Wave modes
    localparam logic [1:0] MODE_TRIANGLE = 2'd1;
    localparam logic [1:0] MODE_SQUARE   = 2'd2;

    // Word slots of one sequence
    localparam logic [2:0] SLOT_RESET_ON  = 3'd0;
    localparam logic [2:0] SLOT_B28_RESET = 3'd1;
    localparam logic [2:0] SLOT_FREQ_LO   = 3'd2;
    localparam logic [2:0] SLOT_FREQ_HI   = 3'd3;
    localparam logic [2:0] SLOT_PHASE     = 3'd4;
    localparam logic [2:0] SLOT_CONTROL   = 3'd5;

endpackage

>>> rtl/dds_waveform_command_sequencer_unit.sv
// DDS waveform command sequencer: tuning/phase pipeline and word serializer.
//
//  channel | dir | fields (low bit up)                        | rate
//  --------+-----+--------------------------------------------+------------------
//  s_axis  | in  | wave_mode[1:0] frequency_hz[33:2]          | 1 request / 6 words
//          |     | phase_deg[42:34], zero fill to 48          |
//  m_axis  | out | spi_word[15:0], tlast = last_word          | 1 word / clk if tready
//
// Each request yields six words; the serializer sends one per cycle while
// m_axis_tready is high. The first word leaves the serializer register after
// the 8 stages. The 8-stage pipeline (two reciprocal divides by 390625, one
// by 45) advances as one; it stalls only when stage 8 holds a result and the
// serializer is still sending. Reset clears the valid bits and the serializer.
module dds_waveform_command_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // wave_mode[1:0], frequency_hz[33:2], phase_deg[42:34]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // spi_word[15:0]
    output logic        m_axis_tlast    // last_word
);

    localparam int unsigned DW = dds_wcs_pkg::DivWidth;

    // request fields
    logic [1:0]  wave_mode;
    logic [31:0] frequency_hz;
    logic [8:0]  phase_deg;
    logic [8:0]  phase_clamped;

    assign wave_mode     = s_axis_tdata[1:0];
    assign frequency_hz  = s_axis_tdata[33:2];
    assign phase_deg     = s_axis_tdata[42:34];
    assign phase_clamped = (phase_deg > dds_wcs_pkg::DEG_MAX) ? dds_wcs_pkg::DEG_MAX
                                                             : phase_deg;

    // pipeline control
    logic [7:0] vld_reg;
    logic [7:0] vld_next;
    logic       adv;
    logic       ser_take;

    // stage registers
    logic [63:0]   s1_prod_reg;     // f * recip
    logic [31:0]   s1_freq_reg;
    logic [36:0]   s1_phprod_reg;   // x * recip45
    logic [17:0]   s1_phx_reg;      // clamped phase * 512
    logic [1:0]    s1_mode_reg;

    logic [13:0]   s2_q0_reg;
    logic [32:0]   s2_qd_reg;
    logic [31:0]   s2_freq_reg;
    logic [11:0]   s2_phq_reg;
    logic [17:0]   s2_phqd_reg;
    logic [17:0]   s2_phx_reg;
    logic [1:0]    s2_mode_reg;

    logic [13:0]   s3_q0_reg;
    logic [19:0]   s3_r0_reg;
    logic [11:0]   s3_phq_reg;
    logic [6:0]    s3_phr_reg;
    logic [1:0]    s3_mode_reg;

    logic [13:0]   s4_qf_reg;
    logic [DW-1:0] s4_rf_reg;
    logic [11:0]   s4_phw_reg;
    logic [1:0]    s4_mode_reg;

    logic [50:0]   s5_prod_reg;     // rf * recip
    logic [13:0]   s5_qf_reg;
    logic [DW-1:0] s5_rf_reg;
    logic [11:0]   s5_phw_reg;
    logic [1:0]    s5_mode_reg;

    logic [21:0]   s6_q2_reg;
    logic [40:0]   s6_qd_reg;
    logic [13:0]   s6_qf_reg;
    logic [DW-1:0] s6_rf_reg;
    logic [11:0]   s6_phw_reg;
    logic [1:0]    s6_mode_reg;

    logic [21:0]   s7_q2_reg;
    logic [19:0]   s7_r2_reg;
    logic [13:0]   s7_qf_reg;
    logic [11:0]   s7_phw_reg;
    logic [1:0]    s7_mode_reg;

    logic [27:0]   s8_tuning_reg;
    logic [11:0]   s8_phw_reg;
    logic [1:0]    s8_mode_reg;

    // serializer
    logic          ser_valid_reg;
    logic          ser_valid_next;
    logic [2:0]    ser_slot_reg;
    logic [2:0]    ser_slot_next;
    logic [27:0]   ser_tuning_reg;
    logic [11:0]   ser_phw_reg;
    logic [1:0]    ser_mode_reg;

    // combinational datapath pieces
    logic [17:0]   phx;
    logic [32:0]   r0_full;
    logic [17:0]   phr_full;
    logic [40:0]   r2_full;
    logic [40:0]   rf_shift;

    assign phx      = {phase_clamped, 9'd0};
    assign r0_full  = {1'b0, s2_freq_reg} - s2_qd_reg;
    assign phr_full = s2_phx_reg - s2_phqd_reg;
    assign rf_shift = {s6_rf_reg, 22'd0};
    assign r2_full  = rf_shift - s6_qd_reg;

    // stall-all pipeline: moves unless stage 8 is full and cannot hand off
    assign ser_take      = !ser_valid_reg ||
                           (m_axis_tready && ser_slot_reg == dds_wcs_pkg::SLOT_CONTROL);
    assign adv           = !vld_reg[7] || ser_take;
    assign s_axis_tready = adv;

    always_comb
    begin
        vld_next = vld_reg;
        if (adv)
        begin
            vld_next = {vld_reg[6:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1: reciprocal products
            s1_prod_reg   <= 64'(frequency_hz * dds_wcs_pkg::DIV_RECIP);
            s1_freq_reg   <= frequency_hz;
            s1_phprod_reg <= 37'(phx * dds_wcs_pkg::PH_RECIP);
            s1_phx_reg    <= phx;
            s1_mode_reg   <= wave_mode;

            // stage 2: estimates and back-multiply
            s2_q0_reg   <= s1_prod_reg[63:50];
            s2_qd_reg   <= 33'(s1_prod_reg[63:50] * dds_wcs_pkg::DIV_D);
            s2_freq_reg <= s1_freq_reg;
            s2_phq_reg  <= s1_phprod_reg[35:24];
            s2_phqd_reg <= 18'(s1_phprod_reg[35:24] * dds_wcs_pkg::PH_DIV);
            s2_phx_reg  <= s1_phx_reg;
            s2_mode_reg <= s1_mode_reg;

            // stage 3: remainders
            s3_q0_reg   <= s2_q0_reg;
            s3_r0_reg   <= r0_full[19:0];
            s3_phq_reg  <= s2_phq_reg;
            s3_phr_reg  <= phr_full[6:0];
            s3_mode_reg <= s2_mode_reg;

            // stage 4: one-step correction
            if (s3_r0_reg >= 20'(dds_wcs_pkg::DIV_D))
            begin
                s4_qf_reg <= s3_q0_reg + 14'd1;
                s4_rf_reg <= DW'(s3_r0_reg - 20'(dds_wcs_pkg::DIV_D));
            end
            else
            begin
                s4_qf_reg <= s3_q0_reg;
                s4_rf_reg <= s3_r0_reg[DW-1:0];
            end
            if (s3_phr_reg >= 7'(dds_wcs_pkg::PH_DIV))
            begin
                s4_phw_reg <= s3_phq_reg + 12'd1;
            end
            else
            begin
                s4_phw_reg <= s3_phq_reg;
            end
            s4_mode_reg <= s3_mode_reg;

            // stage 5: fractional part product
            s5_prod_reg <= 51'(s4_rf_reg * dds_wcs_pkg::DIV_RECIP);
            s5_qf_reg   <= s4_qf_reg;
            s5_rf_reg   <= s4_rf_reg;
            s5_phw_reg  <= s4_phw_reg;
            s5_mode_reg <= s4_mode_reg;

            // stage 6
            s6_q2_reg   <= s5_prod_reg[49:28];
            s6_qd_reg   <= 41'(s5_prod_reg[49:28] * dds_wcs_pkg::DIV_D);
            s6_qf_reg   <= s5_qf_reg;
            s6_rf_reg   <= s5_rf_reg;
            s6_phw_reg  <= s5_phw_reg;
            s6_mode_reg <= s5_mode_reg;

            // stage 7
            s7_q2_reg   <= s6_q2_reg;
            s7_r2_reg   <= r2_full[19:0];
            s7_qf_reg   <= s6_qf_reg;
            s7_phw_reg  <= s6_phw_reg;
            s7_mode_reg <= s6_mode_reg;

            // stage 8: correct q2 by one, tuning = (qf << 22) + q2, low 28 bits
            if (s7_r2_reg >= 20'(dds_wcs_pkg::DIV_D))
            begin
                s8_tuning_reg <= {s7_qf_reg[5:0], s7_q2_reg + 22'd1};
            end
            else
            begin
                s8_tuning_reg <= {s7_qf_reg[5:0], s7_q2_reg};
            end
            s8_phw_reg  <= s7_phw_reg;
            s8_mode_reg <= s7_mode_reg;
        end
    end

    // serializer control
    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        ser_slot_next  = ser_slot_reg;
        if (ser_take)
        begin
            ser_valid_next = vld_reg[7];
            ser_slot_next  = dds_wcs_pkg::SLOT_RESET_ON;
        end
        else if (m_axis_tready)
        begin
            ser_slot_next = ser_slot_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_slot_reg  <= dds_wcs_pkg::SLOT_RESET_ON;
        end
        else
        begin
            ser_valid_reg <= ser_valid_next;
            ser_slot_reg  <= ser_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_take && vld_reg[7])
        begin
            ser_tuning_reg <= s8_tuning_reg;
            ser_phw_reg    <= s8_phw_reg;
            ser_mode_reg   <= s8_mode_reg;
        end
    end

    // word select
    always_comb
    begin
        unique case (ser_slot_reg)
            dds_wcs_pkg::SLOT_RESET_ON:  m_axis_tdata = dds_wcs_pkg::CMD_RESET_ON;
            dds_wcs_pkg::SLOT_B28_RESET: m_axis_tdata = dds_wcs_pkg::CMD_B28_RESET;
            dds_wcs_pkg::SLOT_FREQ_LO:
                m_axis_tdata = dds_wcs_pkg::CMD_FREQ0 | {2'b00, ser_tuning_reg[13:0]};
            dds_wcs_pkg::SLOT_FREQ_HI:
                m_axis_tdata = dds_wcs_pkg::CMD_FREQ0 | {2'b00, ser_tuning_reg[27:14]};
            dds_wcs_pkg::SLOT_PHASE:
                m_axis_tdata = dds_wcs_pkg::CMD_PHASE0 | {4'b0000, ser_phw_reg};
            dds_wcs_pkg::SLOT_CONTROL:
            begin
                if (ser_mode_reg == dds_wcs_pkg::MODE_TRIANGLE)
                begin
                    m_axis_tdata = dds_wcs_pkg::CTRL_BASE | dds_wcs_pkg::CTRL_TRIANGLE;
                end
                else if (ser_mode_reg == dds_wcs_pkg::MODE_SQUARE)
                begin
                    m_axis_tdata = dds_wcs_pkg::CTRL_BASE | dds_wcs_pkg::CTRL_SQUARE;
                end
                else
                begin
                    m_axis_tdata = dds_wcs_pkg::CTRL_BASE;
                end
            end
            default: m_axis_tdata = dds_wcs_pkg::CMD_RESET_ON;
        endcase
    end

    assign m_axis_tvalid = ser_valid_reg;
    assign m_axis_tlast  = (ser_slot_reg == dds_wcs_pkg::SLOT_CONTROL);

endmodule
